// File: hw/rtl/amb_pkg.sv
// ----------------------------------------------------------------------------
// amb_pkg
// Shared types and constants of the adjacency multilist builder: field
// widths, status and command codes, the command word and queue status.
// ----------------------------------------------------------------------------
package amb_pkg;

   localparam int NODE_W = 6;
   localparam int EDGE_W = 7;
   localparam int STAT_W = 3;

   localparam logic [NODE_W-1:0] NODE_COUNT_RST = 6'd63;

   // result status codes
   localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_NODE  = 3'd2;
   localparam logic [STAT_W-1:0] ST_SELF_LOOP = 3'd3;
   localparam logic [STAT_W-1:0] ST_DUMP      = 3'd4;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

   // request codes on the input channel
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_DUMP = 1'b1;

   // command kinds passed from front to back
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] CMD_DUMP   = 2'd1;
   localparam logic [KIND_W-1:0] CMD_REJECT = 2'd2;

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [STAT_W-1:0] status;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } cmd_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qstat_type;

endpackage

// File: hw/rtl/amb_ifs.sv
// ----------------------------------------------------------------------------
// amb request and response channels
// Valid/ready channels of the adjacency multilist builder with their payload.
// ----------------------------------------------------------------------------
interface amb_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [amb_pkg::NODE_W-1:0] node_a;
   logic [amb_pkg::NODE_W-1:0] node_b;

   modport source (output valid, req_type, node_a, node_b, input ready);
   modport sink   (input valid, req_type, node_a, node_b, output ready);
endinterface

interface amb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [amb_pkg::STAT_W-1:0] status;
   logic [amb_pkg::EDGE_W-1:0] edge_id;
   logic [amb_pkg::NODE_W-1:0] end_u;
   logic [amb_pkg::NODE_W-1:0] end_v;
   logic [amb_pkg::EDGE_W-1:0] link_u;
   logic [amb_pkg::EDGE_W-1:0] link_v;
   logic                      last;

   modport source (output valid, status, edge_id, end_u, end_v, link_u, link_v, last,
                   input ready);
   modport sink   (input valid, status, edge_id, end_u, end_v, link_u, link_v, last,
                   output ready);
endinterface

// File: hw/rtl/amb_front.sv
// ----------------------------------------------------------------------------
// amb_front
// Accepts request beats, holds the node count register and classifies each
// request into an add, a dump or an immediate reject.
// ----------------------------------------------------------------------------
module amb_front #(
   parameter int MAX_NODES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [amb_pkg::NODE_W-1:0] csr_wdata,
   amb_req_if.sink                    req,
   input  amb_pkg::qstat_type         q_stat,
   output logic                       q_push,
   output amb_pkg::cmd_type           q_cmd
);

   localparam logic [amb_pkg::NODE_W:0] NODE_LIM = (amb_pkg::NODE_W + 1)'(MAX_NODES);

   logic [amb_pkg::NODE_W-1:0] node_count_ff;
   logic [amb_pkg::NODE_W-1:0] node_count_in;
   logic                       a_ok;
   logic                       b_ok;

   always_comb begin
      node_count_in = csr_we ? csr_wdata : node_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= amb_pkg::NODE_COUNT_RST;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign a_ok = (req.node_a != '0) && (req.node_a <= node_count_ff) &&
                 ({1'b0, req.node_a} < NODE_LIM);
   assign b_ok = (req.node_b != '0) && (req.node_b <= node_count_ff) &&
                 ({1'b0, req.node_b} < NODE_LIM);

   // no beat is taken while reset is held
   assign req.ready = !reset && !q_stat.full;
   assign q_push    = req.valid && !reset && !q_stat.full;

   always_comb begin
      q_cmd.node_a = req.node_a;
      q_cmd.node_b = req.node_b;
      q_cmd.status = amb_pkg::ST_ADDED;
      q_cmd.kind   = amb_pkg::CMD_ADD;
      if (req.req_type == amb_pkg::REQ_DUMP) begin
         q_cmd.kind = amb_pkg::CMD_DUMP;
      end else if (!a_ok || !b_ok) begin
         q_cmd.kind   = amb_pkg::CMD_REJECT;
         q_cmd.status = amb_pkg::ST_BAD_NODE;
      end else if (req.node_a == req.node_b) begin
         q_cmd.kind   = amb_pkg::CMD_REJECT;
         q_cmd.status = amb_pkg::ST_SELF_LOOP;
      end
   end

endmodule

// File: hw/rtl/amb_queue.sv
// ----------------------------------------------------------------------------
// amb_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module amb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  amb_pkg::cmd_type     push_cmd,
   input  logic                 pop,
   output amb_pkg::cmd_type     head_cmd,
   output amb_pkg::qstat_type   stat
);

   amb_pkg::cmd_type                 entry_ff [amb_pkg::QDEPTH];
   logic [amb_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [amb_pkg::QPTR_W-1:0]       wr_ptr_in;
   logic [amb_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [amb_pkg::QPTR_W-1:0]       rd_ptr_in;
   logic [amb_pkg::QCNT_W-1:0]       count_ff;
   logic [amb_pkg::QCNT_W-1:0]       count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == amb_pkg::QCNT_W'(amb_pkg::QDEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// File: hw/rtl/amb_back.sv
// ----------------------------------------------------------------------------
// amb_back
// Executes queued commands against the edge store and the per-node tail
// table, and drives the registered response channel.
// ----------------------------------------------------------------------------
module amb_back #(
   parameter int MAX_EDGES = 64,
   parameter int MAX_NODES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  amb_pkg::cmd_type     head_cmd,
   input  amb_pkg::qstat_type   q_stat,
   output logic                 q_pop,
   amb_rsp_if.source            rsp
);

   localparam int EIW = $clog2(MAX_EDGES + 1);
   localparam int NIW = $clog2(MAX_NODES);
   localparam int NW  = amb_pkg::NODE_W;
   localparam logic [EIW-1:0] EDGE_LIM = EIW'(MAX_EDGES);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_HOOK_A   = 3'd1;
   localparam logic [2:0] S_HOOK_B   = 3'd2;
   localparam logic [2:0] S_DUMP_RD  = 3'd3;
   localparam logic [2:0] S_DUMP_OUT = 3'd4;

   // edge store split by field so a link can be patched without a read
   logic [2*NW-1:0] ends_mem [0:MAX_EDGES];
   logic [EIW-1:0]  nxu_mem  [0:MAX_EDGES];
   logic [EIW-1:0]  nxv_mem  [0:MAX_EDGES];
   // tail entry: top bit set when the node is the second end of that edge
   logic [EIW:0]    tail_mem [0:MAX_NODES-1];

   logic [MAX_NODES-1:0] tail_vld_ff;
   logic [MAX_NODES-1:0] tail_vld_in;

   logic [2:0]      state_ff;
   logic [2:0]      state_in;
   logic [EIW-1:0]  edges_used_ff;
   logic [EIW-1:0]  edges_used_in;
   logic [EIW-1:0]  idx_ff;
   logic [EIW-1:0]  idx_in;
   logic [NW-1:0]   lat_a_ff;
   logic [NW-1:0]   lat_a_in;
   logic [NW-1:0]   lat_b_ff;
   logic [NW-1:0]   lat_b_in;

   logic [EIW:0]    tail_a_ff;
   logic [EIW:0]    tail_b_ff;
   logic            tail_a_vld_ff;
   logic            tail_b_vld_ff;
   logic [2*NW-1:0] rd_ends_ff;
   logic [EIW-1:0]  rd_nxu_ff;
   logic [EIW-1:0]  rd_nxv_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [amb_pkg::STAT_W-1:0] rsp_status_ff;
   logic [amb_pkg::STAT_W-1:0] rsp_status_in;
   logic [EIW-1:0]             rsp_id_ff;
   logic [EIW-1:0]             rsp_id_in;
   logic [NW-1:0]              rsp_eu_ff;
   logic [NW-1:0]              rsp_eu_in;
   logic [NW-1:0]              rsp_ev_ff;
   logic [NW-1:0]              rsp_ev_in;
   logic [EIW-1:0]             rsp_lu_ff;
   logic [EIW-1:0]             rsp_lu_in;
   logic [EIW-1:0]             rsp_lv_ff;
   logic [EIW-1:0]             rsp_lv_in;
   logic                       rsp_last_ff;
   logic                       rsp_last_in;
   logic                       load;

   logic            out_free;
   logic [EIW-1:0]  new_id;
   logic            ends_we;
   logic            ends_re;
   logic            nxu_we;
   logic [EIW-1:0]  nxu_waddr;
   logic [EIW-1:0]  nxu_wdata;
   logic            nxv_we;
   logic [EIW-1:0]  nxv_waddr;
   logic [EIW-1:0]  nxv_wdata;
   logic            tail_re;
   logic            tail_we;
   logic [NIW-1:0]  tail_waddr;
   logic [EIW:0]    tail_wdata;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign new_id   = edges_used_ff + EIW'(1);

   always_comb begin
      state_in      = state_ff;
      edges_used_in = edges_used_ff;
      idx_in        = idx_ff;
      lat_a_in      = lat_a_ff;
      lat_b_in      = lat_b_ff;
      tail_vld_in   = tail_vld_ff;
      q_pop         = 1'b0;
      load          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = '0;
      rsp_eu_in     = '0;
      rsp_ev_in     = '0;
      rsp_lu_in     = '0;
      rsp_lv_in     = '0;
      rsp_last_in   = 1'b1;
      ends_we       = 1'b0;
      ends_re       = 1'b0;
      nxu_we        = 1'b0;
      nxu_waddr     = new_id;
      nxu_wdata     = '0;
      nxv_we        = 1'b0;
      nxv_waddr     = new_id;
      nxv_wdata     = '0;
      tail_re       = 1'b0;
      tail_we       = 1'b0;
      tail_waddr    = lat_a_ff[NIW-1:0];
      tail_wdata    = {1'b0, new_id};

      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty && out_free) begin
               q_pop = 1'b1;
               unique case (head_cmd.kind)
                  amb_pkg::CMD_REJECT: begin
                     load          = 1'b1;
                     rsp_status_in = head_cmd.status;
                  end
                  amb_pkg::CMD_ADD: begin
                     if (edges_used_ff == EDGE_LIM) begin
                        load          = 1'b1;
                        rsp_status_in = amb_pkg::ST_FULL;
                     end else begin
                        // new entry starts with both links at end of list
                        ends_we  = 1'b1;
                        nxu_we   = 1'b1;
                        nxv_we   = 1'b1;
                        tail_re  = 1'b1;
                        lat_a_in = head_cmd.node_a;
                        lat_b_in = head_cmd.node_b;
                        state_in = S_HOOK_A;
                     end
                  end
                  amb_pkg::CMD_DUMP: begin
                     if (edges_used_ff == '0) begin
                        load          = 1'b1;
                        rsp_status_in = amb_pkg::ST_EMPTY;
                     end else begin
                        idx_in   = EIW'(1);
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                     load          = 1'b1;
                     rsp_status_in = head_cmd.status;
                  end
               endcase
            end
         end
         S_HOOK_A: begin
            if (tail_a_vld_ff) begin
               if (tail_a_ff[EIW]) begin
                  nxv_we    = 1'b1;
                  nxv_waddr = tail_a_ff[EIW-1:0];
                  nxv_wdata = new_id;
               end else begin
                  nxu_we    = 1'b1;
                  nxu_waddr = tail_a_ff[EIW-1:0];
                  nxu_wdata = new_id;
               end
            end
            tail_we                        = 1'b1;
            tail_waddr                     = lat_a_ff[NIW-1:0];
            tail_wdata                     = {1'b0, new_id};
            tail_vld_in[lat_a_ff[NIW-1:0]] = 1'b1;
            state_in                       = S_HOOK_B;
         end
         S_HOOK_B: begin
            if (out_free) begin
               if (tail_b_vld_ff) begin
                  if (tail_b_ff[EIW]) begin
                     nxv_we    = 1'b1;
                     nxv_waddr = tail_b_ff[EIW-1:0];
                     nxv_wdata = new_id;
                  end else begin
                     nxu_we    = 1'b1;
                     nxu_waddr = tail_b_ff[EIW-1:0];
                     nxu_wdata = new_id;
                  end
               end
               tail_we                        = 1'b1;
               tail_waddr                     = lat_b_ff[NIW-1:0];
               tail_wdata                     = {1'b1, new_id};
               tail_vld_in[lat_b_ff[NIW-1:0]] = 1'b1;
               edges_used_in                  = new_id;
               load                           = 1'b1;
               rsp_status_in                  = amb_pkg::ST_ADDED;
               rsp_id_in                      = new_id;
               state_in                       = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            ends_re  = 1'b1;
            state_in = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = amb_pkg::ST_DUMP;
               rsp_id_in     = idx_ff;
               rsp_eu_in     = rd_ends_ff[2*NW-1:NW];
               rsp_ev_in     = rd_ends_ff[NW-1:0];
               rsp_lu_in     = rd_nxu_ff;
               rsp_lv_in     = rd_nxv_ff;
               rsp_last_in   = (idx_ff == edges_used_ff);
               if (idx_ff == edges_used_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + EIW'(1);
                  state_in = S_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         edges_used_ff <= '0;
         tail_vld_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edges_used_ff <= edges_used_in;
         tail_vld_ff   <= tail_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      lat_a_ff <= lat_a_in;
      lat_b_ff <= lat_b_in;
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_eu_ff     <= rsp_eu_in;
         rsp_ev_ff     <= rsp_ev_in;
         rsp_lu_ff     <= rsp_lu_in;
         rsp_lv_ff     <= rsp_lv_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // edge store
   always_ff @(posedge clock) begin
      if (ends_we) begin
         ends_mem[new_id] <= {head_cmd.node_a, head_cmd.node_b};
      end
      if (ends_re) begin
         rd_ends_ff <= ends_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (nxu_we) begin
         nxu_mem[nxu_waddr] <= nxu_wdata;
      end
      if (ends_re) begin
         rd_nxu_ff <= nxu_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (nxv_we) begin
         nxv_mem[nxv_waddr] <= nxv_wdata;
      end
      if (ends_re) begin
         rd_nxv_ff <= nxv_mem[idx_ff];
      end
   end

   // tail table, two read ports for both endpoints
   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[tail_waddr] <= tail_wdata;
      end
      if (tail_re) begin
         tail_a_ff     <= tail_mem[head_cmd.node_a[NIW-1:0]];
         tail_b_ff     <= tail_mem[head_cmd.node_b[NIW-1:0]];
         tail_a_vld_ff <= tail_vld_ff[head_cmd.node_a[NIW-1:0]];
         tail_b_vld_ff <= tail_vld_ff[head_cmd.node_b[NIW-1:0]];
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = rsp_status_ff;
   assign rsp.edge_id = amb_pkg::EDGE_W'(rsp_id_ff);
   assign rsp.end_u   = rsp_eu_ff;
   assign rsp.end_v   = rsp_ev_ff;
   assign rsp.link_u  = amb_pkg::EDGE_W'(rsp_lu_ff);
   assign rsp.link_v  = amb_pkg::EDGE_W'(rsp_lv_ff);
   assign rsp.last    = rsp_last_ff;

endmodule

// File: hw/rtl/adjacency_multilist_builder.sv
// ----------------------------------------------------------------------------
// adjacency_multilist_builder
// Builds an undirected graph's adjacency multilist one edge at a time and
// dumps the stored edges in index order on request.
//
//   channel   dir  handshake      payload
//   req_ch    in   valid/ready    req_type, node_a, node_b
//   rsp_ch    out  valid/ready    status, edge_id, end_u, end_v, link_u, link_v, last
//   csr       in   csr_we         csr_wdata (node count)
//
// A reject, full-table or empty-dump request is answered straight from idle in the back end.
// An accepted add does the tail lookup, then one link patch for each
// endpoint, since each link store has a single write port.
// A dump handles each edge in turn: a registered read, then the result beat.
// Reset clears the tail valid flags and the edge count at once; no clearing pass.
// The front keeps taking requests into a 2-entry queue, until it is full, while the back waits on rsp.
// ----------------------------------------------------------------------------
module adjacency_multilist_builder #(
   parameter int MAX_EDGES = 64,
   parameter int MAX_NODES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [amb_pkg::NODE_W-1:0] csr_wdata,
   amb_req_if.sink                    req_ch,
   amb_rsp_if.source                  rsp_ch
);

   amb_pkg::cmd_type   push_cmd;
   amb_pkg::cmd_type   head_cmd;
   amb_pkg::qstat_type q_stat;
   logic               q_push;
   logic               q_pop;

   amb_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   amb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   amb_back #(
      .MAX_EDGES (MAX_EDGES),
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .rsp      (rsp_ch)
   );

   // queue occupancy stays within its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= amb_pkg::QCNT_W'(amb_pkg::QDEPTH))
      else $error("command queue over depth");

   // a push with no pop grows the queue by exactly one
   a_queue_grow: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
      else $error("command queue count slip");

   // every beat other than a dump entry closes its request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != amb_pkg::ST_DUMP) |-> rsp_ch.last)
      else $error("single-result beat without last");

   // a dump continues with the next edge index until its last beat
   a_dump_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == amb_pkg::ST_DUMP && !rsp_ch.last)
      |=> (!rsp_ch.valid || (rsp_ch.status == amb_pkg::ST_DUMP &&
                             rsp_ch.edge_id == $past(rsp_ch.edge_id) + 1'b1)))
      else $error("dump beats out of order");

endmodule
